[design/shape_pair_overlap_test_defines.svh]
// assertion macros for the shape pair overlap tester
`ifndef SHAPE_PAIR_OVERLAP_TEST_DEFINES_SVH
`define SHAPE_PAIR_OVERLAP_TEST_DEFINES_SVH

// antecedent holds now, consequent holds at the same edge
`define SPOT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds now, consequent holds at the next edge
`define SPOT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/spot_pkg.sv]
// shared types and constants of the shape pair overlap tester
`default_nettype none

package spot_pkg;

  localparam int COORD_BITS = 16;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  localparam int DIST_BITS  = COORD_BITS;
  localparam int SQ_BITS    = 2 * COORD_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [SIZE_BITS-1:0]  size_t;
  typedef logic        [DIST_BITS-1:0]  dist_t;
  typedef logic        [SQ_BITS-1:0]    sq_t;

  typedef enum logic {
    SHAPE_RECT   = 1'b0,
    SHAPE_CIRCLE = 1'b1
  } shape_kind_t;

  typedef struct packed {
    shape_kind_t kind;
    coord_t      x;
    coord_t      y;
    size_t       w;
    size_t       h;
  } shape_t;

  typedef struct packed {
    shape_t src;
    shape_t dst;
  } pair_t;

  // geometry stage result: either a finished box test or a distance test
  typedef struct packed {
    logic  box_pair;
    logic  box_hit;
    logic  pre_miss;
    logic  strict;
    dist_t ax;
    dist_t ay;
    dist_t lim;
  } geom_t;

  typedef struct packed {
    logic box_pair;
    logic box_hit;
    logic pre_miss;
    logic strict;
    sq_t  sx;
    sq_t  sy;
    sq_t  l2;
  } square_t;

endpackage

`default_nettype wire

[design/spot_in_if.sv]
// request channel carrying one pair of shapes
`default_nettype none

interface spot_in_if;
  logic            valid;
  logic            ready;
  logic            src_shape;
  spot_pkg::coord_t src_x;
  spot_pkg::coord_t src_y;
  spot_pkg::size_t  src_w;
  spot_pkg::size_t  src_h;
  logic            dst_shape;
  spot_pkg::coord_t dst_x;
  spot_pkg::coord_t dst_y;
  spot_pkg::size_t  dst_w;
  spot_pkg::size_t  dst_h;

  modport source (
    output valid, src_shape, src_x, src_y, src_w, src_h,
           dst_shape, dst_x, dst_y, dst_w, dst_h,
    input  ready
  );
  modport sink (
    input  valid, src_shape, src_x, src_y, src_w, src_h,
           dst_shape, dst_x, dst_y, dst_w, dst_h,
    output ready
  );
endinterface

`default_nettype wire

[design/spot_out_if.sv]
// result channel carrying the overlap flag
`default_nettype none

interface spot_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

`default_nettype wire

[design/spot_geom.sv]
// center distances, box test and distance limits for one shape pair
`default_nettype none

module spot_geom (
  input  spot_pkg::pair_t pair,
  output spot_pkg::geom_t geom
);

  localparam int C = spot_pkg::COORD_BITS;

  logic signed [C:0] diff_x;
  logic signed [C:0] diff_y;
  spot_pkg::dist_t   mag_x;
  spot_pkg::dist_t   mag_y;
  logic [C:0]        dx2;
  logic [C:0]        dy2;
  spot_pkg::dist_t   sum_w;
  spot_pkg::dist_t   sum_h;
  spot_pkg::size_t   rect_w;
  spot_pkg::size_t   rect_h;
  spot_pkg::size_t   circ_r;
  logic [C:0]        ex;
  logic [C:0]        ey;
  logic [C:0]        ax;
  logic [C:0]        ay;
  spot_pkg::dist_t   lim;
  logic              src_rect;
  logic              dst_rect;

  always_comb begin
    src_rect = (pair.src.kind == spot_pkg::SHAPE_RECT);
    dst_rect = (pair.dst.kind == spot_pkg::SHAPE_RECT);

    diff_x = $signed({pair.src.x[C-1], pair.src.x}) - $signed({pair.dst.x[C-1], pair.dst.x});
    diff_y = $signed({pair.src.y[C-1], pair.src.y}) - $signed({pair.dst.y[C-1], pair.dst.y});
    mag_x  = diff_x[C] ? spot_pkg::dist_t'(-diff_x) : diff_x[C-1:0];
    mag_y  = diff_y[C] ? spot_pkg::dist_t'(-diff_y) : diff_y[C-1:0];
    dx2    = {mag_x, 1'b0};
    dy2    = {mag_y, 1'b0};

    sum_w = {1'b0, pair.src.w} + {1'b0, pair.dst.w};
    sum_h = {1'b0, pair.src.h} + {1'b0, pair.dst.h};

    // rectangle against circle, in either order
    rect_w = src_rect ? pair.src.w : pair.dst.w;
    rect_h = src_rect ? pair.src.h : pair.dst.h;
    circ_r = src_rect ? pair.dst.w : pair.src.w;
    // distance past the rectangle edge, at twice the scale
    ex = (dx2 > {2'b00, rect_w}) ? dx2 - {2'b00, rect_w} : '0;
    ey = (dy2 > {2'b00, rect_h}) ? dy2 - {2'b00, rect_h} : '0;

    if (src_rect != dst_rect) begin
      ax  = ex;
      ay  = ey;
      lim = {circ_r, 1'b0};
    end else begin
      ax  = {1'b0, mag_x};
      ay  = {1'b0, mag_y};
      lim = sum_w;
    end

    geom.box_pair = src_rect && dst_rect;
    geom.box_hit  = (dx2 < {1'b0, sum_w}) && (dy2 < {1'b0, sum_h});
    geom.pre_miss = (ax > {1'b0, lim}) || (ay > {1'b0, lim});
    geom.strict   = (src_rect == dst_rect);
    geom.ax       = ax[C-1:0];
    geom.ay       = ay[C-1:0];
    geom.lim      = lim;
  end

endmodule

`default_nettype wire

[design/spot_square.sv]
// squares of the two offsets and of the distance limit
`default_nettype none

module spot_square (
  input  spot_pkg::geom_t   geom,
  output spot_pkg::square_t sq
);

  localparam int C = spot_pkg::COORD_BITS;

  always_comb begin
    sq.box_pair = geom.box_pair;
    sq.box_hit  = geom.box_hit;
    sq.pre_miss = geom.pre_miss;
    sq.strict   = geom.strict;
    sq.sx       = {{C{1'b0}}, geom.ax} * {{C{1'b0}}, geom.ax};
    sq.sy       = {{C{1'b0}}, geom.ay} * {{C{1'b0}}, geom.ay};
    sq.l2       = {{C{1'b0}}, geom.lim} * {{C{1'b0}}, geom.lim};
  end

endmodule

`default_nettype wire

[design/shape_pair_overlap_test.sv]
// top level of the shape pair overlap tester
// usage:
//   in_chan carries one request per pair: two shapes, each a centered
//   rectangle (kind 0, full width and height) or a circle (kind 1, radius
//   in the width field), centers signed with 4 fraction bits.
//   out_chan returns one hit flag per request, in request order.
//   both channels use valid/ready; a transfer happens when both are high.
// path: a request taken at a clock edge moves through the input register,
//   geometry register, squares register and result register in order.
// throughput: one request per cycle, sustained while out_ready is high;
//   every stage holds its own valid bit and moves on whenever the stage
//   after it is empty or leaving, and the three squarers sit alone in
//   their own register stage.
// stall: when out_ready is low the result waits in the output register and
//   up to three more requests are still taken into the empty stages behind
//   it; in_ready falls only once all four stages are full.
// reset: rst_n low at a clock edge empties every stage; no result is lost
//   or produced afterwards for requests taken before reset.
`default_nettype none
`include "shape_pair_overlap_test_defines.svh"

module shape_pair_overlap_test (
  input wire logic   clk,
  input wire logic   rst_n,
  spot_in_if.sink    in_chan,
  spot_out_if.source out_chan
);

  // stage valid bits
  logic v0_r, v0_nxt;
  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic vo_r, vo_nxt;

  // stage loads
  logic ld0, ld1, ld2, ldo;

  spot_pkg::pair_t   pair_r;
  spot_pkg::pair_t   pair_nxt;
  spot_pkg::geom_t   geom_r;
  spot_pkg::geom_t   geom_nxt;
  spot_pkg::square_t sq_r;
  spot_pkg::square_t sq_nxt;
  logic              hit_r;
  logic              hit_nxt;

  logic [spot_pkg::SQ_BITS:0] dist2;
  logic [spot_pkg::SQ_BITS:0] lim2;

  // ready ripples back from the output: a stage loads when it is empty
  // or its content leaves in the same cycle
  always_comb begin
    ldo = v2_r && (!vo_r || out_chan.ready);
    ld2 = v1_r && (!v2_r || ldo);
    ld1 = v0_r && (!v1_r || ld2);
    in_chan.ready = !v0_r || ld1;
    ld0 = in_chan.valid && in_chan.ready;

    v0_nxt = ld0 || (v0_r && !ld1);
    v1_nxt = ld1 || (v1_r && !ld2);
    v2_nxt = ld2 || (v2_r && !ldo);
    vo_nxt = ldo || (vo_r && !out_chan.ready);
  end

  // request capture
  always_comb begin
    pair_nxt.src.kind = spot_pkg::shape_kind_t'(in_chan.src_shape);
    pair_nxt.src.x    = in_chan.src_x;
    pair_nxt.src.y    = in_chan.src_y;
    pair_nxt.src.w    = in_chan.src_w;
    pair_nxt.src.h    = in_chan.src_h;
    pair_nxt.dst.kind = spot_pkg::shape_kind_t'(in_chan.dst_shape);
    pair_nxt.dst.x    = in_chan.dst_x;
    pair_nxt.dst.y    = in_chan.dst_y;
    pair_nxt.dst.w    = in_chan.dst_w;
    pair_nxt.dst.h    = in_chan.dst_h;
  end

  spot_geom u_geom (
    .pair (pair_r),
    .geom (geom_nxt)
  );

  spot_square u_square (
    .geom (geom_r),
    .sq   (sq_nxt)
  );

  // final decision: box pairs are already done, the rest compare squared
  always_comb begin
    dist2 = {1'b0, sq_r.sx} + {1'b0, sq_r.sy};
    lim2  = {1'b0, sq_r.l2};
    if (sq_r.box_pair) begin
      hit_nxt = sq_r.box_hit;
    end else if (sq_r.pre_miss) begin
      hit_nxt = 1'b0;
    end else begin
      hit_nxt = sq_r.strict ? (dist2 < lim2) : (dist2 <= lim2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      vo_r <= vo_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (ld0) begin
      pair_r <= pair_nxt;
    end
    if (ld1) begin
      geom_r <= geom_nxt;
    end
    if (ld2) begin
      sq_r <= sq_nxt;
    end
    if (ldo) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_chan.valid = vo_r;
  assign out_chan.hit   = hit_r;

  `SPOT_ASSERT_NOW(a_empty_input_ready, !v0_r, in_chan.ready, "input stage empty but not ready")
  `SPOT_ASSERT_NEXT(a_geom_advance, v0_r && !v1_r, v1_r, "request did not reach geometry stage")
  `SPOT_ASSERT_NEXT(a_out_fill, v2_r && !vo_r, vo_r, "squares stage did not reach output")
  `SPOT_ASSERT_NEXT(a_pre_miss_clear, ldo && sq_r.pre_miss && !sq_r.box_pair, !hit_r,
                    "distance pre-check miss produced a hit")

endmodule

`default_nettype wire

[tb/shape_pair_overlap_test_tb.sv]
// self-checking testbench for the shape pair overlap tester
`default_nettype none

module shape_pair_overlap_test_tb;

  // one stimulus entry: the shape pair and the idling phase it belongs to
  typedef struct {
    spot_pkg::pair_t pair;
    int              phase;
  } queued_pair_t;

  // idling phases: none, sender idle, receiver stalling, both
  localparam int NUM_PHASES = 4;
  localparam int SRC_IDLE_PCT [NUM_PHASES] = '{0, 50, 0, 24};
  localparam int RCV_STALL_PCT[NUM_PHASES] = '{0, 0, 50, 24};

  localparam int RANDOM_PAIRS = 1930;
  localparam int PHASE_SPAN   = 240;
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst_n;

  spot_in_if  in_if ();
  spot_out_if out_if ();

  shape_pair_overlap_test u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  queued_pair_t pair_backlog[$];   // requests not yet offered to the block
  bit           pending_hits[$];   // predicted hit flags, oldest first
  logic         in_taken;          // request on the bus was accepted at the last edge
  int           active_phase;
  int           error_count;

  // 10 time unit clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  function automatic longint abs_val(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // offsets within lim, compared squared; strict or inclusive
  function automatic bit within_reach(longint ax, longint ay, longint lim, bit strict);
    longint sq_sum;
    longint lim_sq;
    if (ax > lim || ay > lim) return 1'b0;
    sq_sum = ax * ax + ay * ay;
    lim_sq = lim * lim;
    return strict ? (sq_sum < lim_sq) : (sq_sum <= lim_sq);
  endfunction

  // clamp a doubled offset to the doubled half span, i.e. the full size
  function automatic longint clamp_to_span(longint d, longint span);
    if (d < -span) return -span;
    if (d > span) return span;
    return d;
  endfunction

  function automatic bit box_box_hit(spot_pkg::shape_t a, spot_pkg::shape_t b);
    longint dx2;
    longint dy2;
    dx2 = 2 * abs_val(longint'($signed(a.x)) - longint'($signed(b.x)));
    dy2 = 2 * abs_val(longint'($signed(a.y)) - longint'($signed(b.y)));
    return (dx2 < longint'(a.w) + longint'(b.w)) && (dy2 < longint'(a.h) + longint'(b.h));
  endfunction

  // everything doubled so the rectangle half sizes stay exact
  function automatic bit box_circle_hit(spot_pkg::shape_t r, spot_pkg::shape_t c);
    longint dx;
    longint dy;
    longint ex;
    longint ey;
    dx = 2 * (longint'($signed(c.x)) - longint'($signed(r.x)));
    dy = 2 * (longint'($signed(c.y)) - longint'($signed(r.y)));
    ex = dx - clamp_to_span(dx, longint'(r.w));
    ey = dy - clamp_to_span(dy, longint'(r.h));
    return within_reach(abs_val(ex), abs_val(ey), 2 * longint'(c.w), 1'b0);
  endfunction

  function automatic bit circle_circle_hit(spot_pkg::shape_t a, spot_pkg::shape_t b);
    return within_reach(abs_val(longint'($signed(a.x)) - longint'($signed(b.x))),
                        abs_val(longint'($signed(a.y)) - longint'($signed(b.y))),
                        longint'(a.w) + longint'(b.w), 1'b1);
  endfunction

  function automatic bit overlap_hit(spot_pkg::pair_t p);
    if (p.src.kind == spot_pkg::SHAPE_RECT && p.dst.kind == spot_pkg::SHAPE_RECT)
      return box_box_hit(p.src, p.dst);
    if (p.src.kind == spot_pkg::SHAPE_RECT) return box_circle_hit(p.src, p.dst);
    if (p.dst.kind == spot_pkg::SHAPE_RECT) return box_circle_hit(p.dst, p.src);
    return circle_circle_hit(p.src, p.dst);
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  function automatic spot_pkg::shape_t make_shape(spot_pkg::shape_kind_t kind, int x, int y,
                                                  int w, int h);
    spot_pkg::shape_t s;
    s.kind = kind;
    s.x    = spot_pkg::coord_t'(x);
    s.y    = spot_pkg::coord_t'(y);
    s.w    = spot_pkg::size_t'(w);
    s.h    = spot_pkg::size_t'(h);
    return s;
  endfunction

  function automatic void queue_pair(spot_pkg::shape_t a, spot_pkg::shape_t b, int phase);
    queued_pair_t e;
    e.pair.src = a;
    e.pair.dst = b;
    e.phase    = phase;
    pair_backlog.insert(pair_backlog.size(), e);
  endfunction

  // small coordinates most often, with zero, the extremes and full-range patterns mixed in
  function automatic spot_pkg::coord_t rand_coord();
    case ($urandom_range(9))
      0:       return spot_pkg::coord_t'(-32768);
      1:       return spot_pkg::coord_t'(32767);
      2:       return '0;
      3, 4, 5: return spot_pkg::coord_t'($urandom);
      default: return spot_pkg::coord_t'(int'($urandom_range(511)) - 256);
    endcase
  endfunction

  function automatic spot_pkg::size_t rand_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return spot_pkg::size_t'(32767);
      2, 3, 4: return spot_pkg::size_t'($urandom);
      default: return spot_pkg::size_t'($urandom_range(600));
    endcase
  endfunction

  function automatic spot_pkg::shape_t rand_shape();
    spot_pkg::shape_t s;
    s.kind = spot_pkg::shape_kind_t'($urandom_range(1));
    s.x    = rand_coord();
    s.y    = rand_coord();
    s.w    = rand_size();
    s.h    = rand_size();
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // driver: requests change on the falling edge
  // ---------------------------------------------------------------------

  always @(negedge clk) begin
    queued_pair_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      // bus is free: offer the next request unless the sender idles this cycle
      if (pair_backlog.size() > 0 &&
          $urandom_range(99) >= SRC_IDLE_PCT[pair_backlog[0].phase]) begin
        nxt = pair_backlog.pop_front();
        active_phase    = nxt.phase;
        in_if.src_shape <= nxt.pair.src.kind;
        in_if.src_x     <= nxt.pair.src.x;
        in_if.src_y     <= nxt.pair.src.y;
        in_if.src_w     <= nxt.pair.src.w;
        in_if.src_h     <= nxt.pair.src.h;
        in_if.dst_shape <= nxt.pair.dst.kind;
        in_if.dst_x     <= nxt.pair.dst.x;
        in_if.dst_y     <= nxt.pair.dst.y;
        in_if.dst_w     <= nxt.pair.dst.w;
        in_if.dst_h     <= nxt.pair.dst.h;
        in_if.valid     <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver stalls at the rate of the current phase
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= RCV_STALL_PCT[active_phase]);
    end
  end

  // ---------------------------------------------------------------------
  // monitor: both channels sampled on the rising edge
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    spot_pkg::pair_t seen;
    bit              want;
    in_taken <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready) begin
      seen.src = make_shape(spot_pkg::shape_kind_t'(in_if.src_shape), in_if.src_x,
                            in_if.src_y, in_if.src_w, in_if.src_h);
      seen.dst = make_shape(spot_pkg::shape_kind_t'(in_if.dst_shape), in_if.dst_x,
                            in_if.dst_y, in_if.dst_w, in_if.dst_h);
      // sizes and coordinates go through int, so re-take the coordinates at field width
      seen.src.x = in_if.src_x;
      seen.src.y = in_if.src_y;
      seen.dst.x = in_if.dst_x;
      seen.dst.y = in_if.dst_y;
      pending_hits.insert(pending_hits.size(), overlap_hit(seen));
    end
    if (rst_n && out_if.valid === 1'b1 && out_if.ready) begin
      if (pending_hits.size() == 0) begin
        $error("hit: result with no request outstanding, actual %0b", out_if.hit);
        error_count++;
      end else begin
        want = pending_hits.pop_front();
        if (out_if.hit !== want) begin
          $error("hit mismatch: expected %0b, actual %0b", want, out_if.hit);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------

  initial begin
    spot_pkg::shape_t a;
    spot_pkg::shape_t b;
    int               off_x;
    int               off_y;

    // every input known from time zero
    rst_n           = 1'b0;
    in_taken        = 1'b0;
    active_phase    = 0;
    error_count     = 0;
    in_if.valid     = 1'b0;
    in_if.src_shape = 1'b0;
    in_if.src_x     = '0;
    in_if.src_y     = '0;
    in_if.src_w     = '0;
    in_if.src_h     = '0;
    in_if.dst_shape = 1'b0;
    in_if.dst_x     = '0;
    in_if.dst_y     = '0;
    in_if.dst_w     = '0;
    in_if.dst_h     = '0;
    out_if.ready    = 1'b0;

    // directed pairs, no idling
    // overlapping boxes, boxes touching on an edge, boxes just inside
    queue_pair(make_shape(spot_pkg::SHAPE_RECT, 0, 0, 32, 32),
               make_shape(spot_pkg::SHAPE_RECT, 0, 0, 16, 16), 0);
    queue_pair(make_shape(spot_pkg::SHAPE_RECT, 0, 0, 32, 32),
               make_shape(spot_pkg::SHAPE_RECT, 32, 0, 32, 32), 0);
    queue_pair(make_shape(spot_pkg::SHAPE_RECT, 0, 0, 32, 32),
               make_shape(spot_pkg::SHAPE_RECT, 31, 0, 32, 32), 0);
    queue_pair(make_shape(spot_pkg::SHAPE_RECT, 0, 0, 32, 32),
               make_shape(spot_pkg::SHAPE_RECT, 0, -32, 32, 32), 0);
    // zero-size boxes at the same center never hit
    queue_pair(make_shape(spot_pkg::SHAPE_RECT, 5, 5, 0, 10),
               make_shape(spot_pkg::SHAPE_RECT, 5, 5, 0, 10), 0);
    // circles touching on a 3-4-5 triangle, then overlapping
    queue_pair(make_shape(spot_pkg::SHAPE_CIRCLE, 0, 0, 2, 0),
               make_shape(spot_pkg::SHAPE_CIRCLE, 3, 4, 3, 0), 0);
    queue_pair(make_shape(spot_pkg::SHAPE_CIRCLE, 0, 0, 2, 0),
               make_shape(spot_pkg::SHAPE_CIRCLE, 3, 4, 4, 0), 0);
    // two zero-radius circles on the same point
    queue_pair(make_shape(spot_pkg::SHAPE_CIRCLE, 7, -7, 0, 9),
               make_shape(spot_pkg::SHAPE_CIRCLE, 7, -7, 0, 3), 0);
    // circle touching a box side is a hit; a little further away it misses (both orders)
    queue_pair(make_shape(spot_pkg::SHAPE_RECT, 0, 0, 32, 32),
               make_shape(spot_pkg::SHAPE_CIRCLE, 26, 0, 10, 0), 0);
    queue_pair(make_shape(spot_pkg::SHAPE_CIRCLE, 27, 0, 10, 0),
               make_shape(spot_pkg::SHAPE_RECT, 0, 0, 32, 32), 0);
    // circle against a box corner: exactly touching, then short by one
    queue_pair(make_shape(spot_pkg::SHAPE_RECT, 0, 0, 32, 32),
               make_shape(spot_pkg::SHAPE_CIRCLE, 19, 20, 5, 0), 0);
    queue_pair(make_shape(spot_pkg::SHAPE_CIRCLE, 19, 20, 4, 7),
               make_shape(spot_pkg::SHAPE_RECT, 0, 0, 32, 32), 0);
    // zero-radius circle inside a box and on its edge
    queue_pair(make_shape(spot_pkg::SHAPE_CIRCLE, 3, -2, 0, 0),
               make_shape(spot_pkg::SHAPE_RECT, 0, 0, 32, 32), 0);
    queue_pair(make_shape(spot_pkg::SHAPE_RECT, 0, 0, 32, 32),
               make_shape(spot_pkg::SHAPE_CIRCLE, 16, 16, 0, 0), 0);
    // center inside the box hits for any radius, zero-height box as a segment
    queue_pair(make_shape(spot_pkg::SHAPE_RECT, 0, 0, 32767, 32767),
               make_shape(spot_pkg::SHAPE_CIRCLE, 100, -100, 0, 32767), 0);
    queue_pair(make_shape(spot_pkg::SHAPE_RECT, 0, 0, 64, 0),
               make_shape(spot_pkg::SHAPE_CIRCLE, 10, 0, 0, 0), 0);
    // extremes of the coordinates and sizes for every kind combination
    queue_pair(make_shape(spot_pkg::SHAPE_RECT, -32768, -32768, 32767, 32767),
               make_shape(spot_pkg::SHAPE_RECT, 32767, 32767, 32767, 32767), 0);
    queue_pair(make_shape(spot_pkg::SHAPE_RECT, -32768, 32767, 32767, 32767),
               make_shape(spot_pkg::SHAPE_CIRCLE, 32767, -32768, 32767, 32767), 0);
    queue_pair(make_shape(spot_pkg::SHAPE_CIRCLE, -32768, -32768, 32767, 32767),
               make_shape(spot_pkg::SHAPE_RECT, 32767, 32767, 0, 0), 0);
    queue_pair(make_shape(spot_pkg::SHAPE_CIRCLE, -32768, -32768, 32767, 0),
               make_shape(spot_pkg::SHAPE_CIRCLE, 32767, 32767, 32767, 0), 0);
    queue_pair(make_shape(spot_pkg::SHAPE_CIRCLE, 32767, 32767, 32767, 32767),
               make_shape(spot_pkg::SHAPE_CIRCLE, 32767, 32767, 32767, 32767), 0);
    queue_pair(make_shape(spot_pkg::SHAPE_RECT, -32768, 0, 32767, 1),
               make_shape(spot_pkg::SHAPE_RECT, -32768, 0, 32767, 1), 0);

    // random pairs, cycling through the idling phases in blocks
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      a = rand_shape();
      b = rand_shape();
      // most pairs put the second center near the first so hits and misses both occur
      if ($urandom_range(9) < 7) begin
        if ($urandom_range(1)) begin
          off_x = int'($urandom_range(1200)) - 600;
          off_y = int'($urandom_range(1200)) - 600;
        end else begin
          off_x = int'($urandom_range(40)) - 20;
          off_y = int'($urandom_range(40)) - 20;
        end
        b.x = spot_pkg::coord_t'(longint'($signed(a.x)) + off_x);
        b.y = spot_pkg::coord_t'(longint'($signed(a.y)) + off_y);
      end
      queue_pair(a, b, (i / PHASE_SPAN) % NUM_PHASES);
    end

    // synchronous reset held low, then released on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // wait until every request is taken and every result has come back
    while (pair_backlog.size() != 0 || in_if.valid || pending_hits.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("shape_pair_overlap_test_tb: clean");
    end else begin
      $display("shape_pair_overlap_test_tb: errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5000000;
    $display("shape_pair_overlap_test_tb: errors");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+design
design/spot_pkg.sv
design/spot_in_if.sv
design/spot_out_if.sv
design/spot_geom.sv
design/spot_square.sv
design/shape_pair_overlap_test.sv
tb/shape_pair_overlap_test_tb.sv
